@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// checked on clk_i, masked while rst_ni is low
`define ARA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
// checked on clk_i, also during reset
`define ARA_ASSERT_NORST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");
`else
`define ARA_ASSERT(lbl, prop)
`define ARA_ASSERT_NORST(lbl, prop)
`endif
`endif

@@ hdl/ara_pkg.sv @@
// ---------------------------------------------------------------------------
// Region allocator package
// Codes, alignment masks and controller/datapath interface types.
// ---------------------------------------------------------------------------
package ara_pkg;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned GAP_W   = 30;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned REG_SEL = 3;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;

  localparam logic [1:0] ALIGN_4K = 2'd0;
  localparam logic [1:0] ALIGN_2M = 2'd1;
  localparam logic [1:0] ALIGN_1G = 2'd2;

  localparam logic [ADDR_W-1:0] SPACE_LIMIT_RST = 64'hFFFF_FFFF_FFFF_F000;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOSPACE  = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BAD      = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    STEP_IDLE, STEP_LOAD, STEP_SRD, STEP_S1, STEP_S2, STEP_FSCAN, STEP_LRD,
    STEP_W1, STEP_W2, STEP_W3, STEP_W4, STEP_J1, STEP_J2, STEP_J3,
    STEP_INIT, STEP_DONE
  } step_e;

  typedef struct packed {
    step_e   step;
    status_e code;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       bad_alloc;
    logic       hit;
    logic       last;
    logic       fs_done;
    logic       out_free;
  } sts_t;

  function automatic logic [GAP_W-1:0] align_mask(input logic [1:0] mode);
    logic [GAP_W-1:0] m;
    case (mode)
      ALIGN_4K: m = 30'h0000_0FFF;
      ALIGN_2M: m = 30'h001F_FFFF;
      default:  m = 30'h3FFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

@@ hdl/ara_dpath.sv @@
// ---------------------------------------------------------------------------
// Region allocator datapath
// Record memories, active/in-use flags, scan arithmetic and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ara_dpath #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ara_pkg::cmd_t            cmd_i,
  output ara_pkg::sts_t            sts_o,
  input  logic [1:0]               op_i,
  input  logic [63:0]              request_size_i,
  input  logic [1:0]               align_mode_i,
  input  logic [63:0]              free_address_i,
  input  logic [63:0]              space_base_i,
  input  logic [63:0]              space_limit_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [2:0]               out_status_o,
  output logic [63:0]              out_addr_o
);
  import ara_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned LW = $clog2(TABLE_DEPTH + 1);
  localparam logic [LW-1:0] LINK_NONE = LW'(TABLE_DEPTH);
  localparam logic [IW-1:0] IDX_LAST  = IW'(TABLE_DEPTH - 1);

  logic [63:0]   start_mem [TABLE_DEPTH];
  logic [63:0]   len_mem   [TABLE_DEPTH];
  logic [LW-1:0] prev_mem  [TABLE_DEPTH];
  logic [LW-1:0] next_mem  [TABLE_DEPTH];

  logic [63:0]   rd_st, rd_len;
  logic [LW-1:0] rd_prev, rd_next;
  logic          rd_en;
  logic [IW-1:0] rd_addr;

  logic          st_we, len_we, prv_we, nxt_we;
  logic [IW-1:0] st_wa, len_wa, prv_wa, nxt_wa;
  logic [63:0]   st_wd, len_wd;
  logic [LW-1:0] prv_wd, nxt_wd;

  logic [TABLE_DEPTH-1:0] act_q, use_q;
  logic [IW-1:0] idx_q, fa_q, fb_q, cur_q;
  logic [1:0]    have_q;
  logic          out_valid_q;

  logic [1:0]    op_q, mode_q;
  logic [63:0]   size_q, faddr_q;
  logic [63:0]   aligned_q, rem_q, tail_q, st_q, len_q, addr_q, lenc_q;
  logic [GAP_W-1:0] gap_q;
  logic          skip_q;
  logic [LW-1:0] p_q, n_q, nxt_q;
  logic [2:0]    out_status_q;
  logic [63:0]   out_addr_q;

  // scan arithmetic
  logic [GAP_W-1:0] mask, gap;
  logic [64:0]   align_sum, diff_w, tail_w, init_w;
  logic          is_alloc, hit, gap_nz, tail_nz, found, fs_done, j1, j2, out_free;
  logic [1:0]    need;
  logic [IW-1:0] t_idx;
  logic [LW-1:0] cur_link;

  assign is_alloc  = (op_q == OP_ALLOC);
  assign mask      = align_mask(mode_q);
  assign gap       = (GAP_W'(0) - rd_st[GAP_W-1:0]) & mask;
  assign align_sum = {1'b0, rd_st} + {35'd0, gap};
  assign diff_w    = {1'b0, faddr_q} - {1'b0, rd_st};
  assign tail_w    = {1'b0, rem_q} - {1'b0, size_q};
  assign init_w    = {1'b0, space_limit_i} - {1'b0, space_base_i};

  assign hit = is_alloc ? (!skip_q && !tail_w[64]) : (!skip_q && (rem_q < rd_len));

  assign gap_nz   = (gap_q != '0);
  assign tail_nz  = (tail_q != '0);
  assign need     = {1'b0, gap_nz} + {1'b0, tail_nz};
  assign found    = !act_q[idx_q];
  assign fs_done  = (have_q == need) || (found && ((have_q + 2'd1) == need));
  assign t_idx    = gap_nz ? fb_q : fa_q;
  assign cur_link = LW'(cur_q);
  assign out_free = !out_valid_q || out_ready_i;

  assign j1 = (n_q < LINK_NONE) && (n_q != cur_link) && act_q[n_q[IW-1:0]] &&
              !use_q[n_q[IW-1:0]] && (rd_prev == cur_link);
  assign j2 = (p_q < LINK_NONE) && (p_q != cur_link) && act_q[p_q[IW-1:0]] &&
              !use_q[p_q[IW-1:0]] && (rd_next == cur_link);

  assign sts_o = '{op:        op_q,
                   bad_alloc: (size_q == '0) || (mode_q > ALIGN_1G),
                   hit:       hit,
                   last:      (idx_q == IDX_LAST),
                   fs_done:   fs_done,
                   out_free:  out_free};

  // read port select
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_q;
    case (cmd_i.step)
      STEP_SRD: rd_en = 1'b1;
      STEP_S2: begin
        rd_en   = !hit && (idx_q != IDX_LAST);
        rd_addr = idx_q + 1'b1;
      end
      STEP_LRD: begin
        rd_en   = 1'b1;
        rd_addr = cur_q;
      end
      STEP_J1: begin
        rd_en   = 1'b1;
        rd_addr = rd_next[IW-1:0];
      end
      STEP_J2: begin
        rd_en   = 1'b1;
        rd_addr = p_q[IW-1:0];
      end
      default: ;
    endcase
  end

  // write port select
  always_comb begin
    st_we = 1'b0; st_wa = '0; st_wd = '0;
    len_we = 1'b0; len_wa = '0; len_wd = '0;
    prv_we = 1'b0; prv_wa = '0; prv_wd = '0;
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
    case (cmd_i.step)
      STEP_INIT: begin
        st_we = 1'b1; st_wd = space_base_i;
        len_we = 1'b1; len_wd = init_w[64] ? 64'd0 : init_w[63:0];
        prv_we = 1'b1; prv_wd = LINK_NONE;
        nxt_we = 1'b1; nxt_wd = LINK_NONE;
      end
      STEP_W1: begin
        // front gap record
        if (gap_nz) begin
          st_we = 1'b1; st_wa = fa_q; st_wd = st_q;
          len_we = 1'b1; len_wa = fa_q; len_wd = {34'd0, gap_q};
          prv_we = 1'b1; prv_wa = fa_q; prv_wd = rd_prev;
          nxt_we = 1'b1; nxt_wa = fa_q; nxt_wd = cur_link;
        end
      end
      STEP_W2: begin
        st_we = 1'b1; st_wa = cur_q; st_wd = aligned_q;
        len_we = 1'b1; len_wa = cur_q; len_wd = size_q;
        if (gap_nz) begin
          prv_we = 1'b1; prv_wa = cur_q; prv_wd = LW'(fa_q);
          if (rd_prev < LINK_NONE) begin
            nxt_we = 1'b1; nxt_wa = rd_prev[IW-1:0]; nxt_wd = LW'(fa_q);
          end
        end
      end
      STEP_W3: begin
        // tail record
        if (tail_nz) begin
          st_we = 1'b1; st_wa = t_idx; st_wd = aligned_q + size_q;
          len_we = 1'b1; len_wa = t_idx; len_wd = tail_q;
          prv_we = 1'b1; prv_wa = t_idx; prv_wd = cur_link;
          nxt_we = 1'b1; nxt_wa = t_idx; nxt_wd = rd_next;
        end
      end
      STEP_W4: begin
        if (tail_nz) begin
          nxt_we = 1'b1; nxt_wa = cur_q; nxt_wd = LW'(t_idx);
          if (rd_next < LINK_NONE) begin
            prv_we = 1'b1; prv_wa = rd_next[IW-1:0]; prv_wd = LW'(t_idx);
          end
        end
      end
      STEP_J2: begin
        // absorb the next neighbor
        if (j1) begin
          len_we = 1'b1; len_wa = cur_q; len_wd = len_q + rd_len;
          nxt_we = 1'b1; nxt_wa = cur_q; nxt_wd = rd_next;
          if (rd_next < LINK_NONE) begin
            prv_we = 1'b1; prv_wa = rd_next[IW-1:0]; prv_wd = cur_link;
          end
        end
      end
      STEP_J3: begin
        // fold into the previous neighbor
        if (j2) begin
          len_we = 1'b1; len_wa = p_q[IW-1:0]; len_wd = rd_len + lenc_q;
          nxt_we = 1'b1; nxt_wa = p_q[IW-1:0]; nxt_wd = nxt_q;
          if (nxt_q < LINK_NONE) begin
            prv_we = 1'b1; prv_wa = nxt_q[IW-1:0]; prv_wd = p_q;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_st   <= start_mem[rd_addr];
      rd_len  <= len_mem[rd_addr];
      rd_prev <= prev_mem[rd_addr];
      rd_next <= next_mem[rd_addr];
    end
    if (st_we) start_mem[st_wa] <= st_wd;
    if (len_we) len_mem[len_wa] <= len_wd;
    if (prv_we) prev_mem[prv_wa] <= prv_wd;
    if (nxt_we) next_mem[nxt_wa] <= nxt_wd;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= '0;
      use_q       <= '0;
      idx_q       <= '0;
      have_q      <= '0;
      fa_q        <= '0;
      fb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((cmd_i.step == STEP_DONE) && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.step)
        STEP_LOAD: idx_q <= '0;
        STEP_S2: begin
          if (hit) begin
            idx_q  <= '0;
            have_q <= '0;
            if (!is_alloc) use_q[idx_q] <= 1'b0;
          end else if (idx_q != IDX_LAST) begin
            idx_q <= idx_q + 1'b1;
          end
        end
        STEP_FSCAN: begin
          if (found && (have_q != need)) begin
            if (have_q == 2'd0) fa_q <= idx_q;
            else fb_q <= idx_q;
            have_q <= have_q + 2'd1;
          end
          if (idx_q != IDX_LAST) idx_q <= idx_q + 1'b1;
        end
        STEP_W1: begin
          if (gap_nz) begin
            act_q[fa_q] <= 1'b1;
            use_q[fa_q] <= 1'b0;
          end
        end
        STEP_W2: use_q[cur_q] <= 1'b1;
        STEP_W3: begin
          if (tail_nz) begin
            act_q[t_idx] <= 1'b1;
            use_q[t_idx] <= 1'b0;
          end
        end
        STEP_J2: begin
          if (j1) begin
            act_q[n_q[IW-1:0]] <= 1'b0;
            use_q[n_q[IW-1:0]] <= 1'b0;
          end
        end
        STEP_J3: begin
          if (j2) begin
            act_q[cur_q] <= 1'b0;
            use_q[cur_q] <= 1'b0;
          end
        end
        STEP_INIT: begin
          act_q <= TABLE_DEPTH'(1);
          use_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.step)
      STEP_LOAD: begin
        op_q    <= op_i;
        size_q  <= request_size_i;
        mode_q  <= align_mode_i;
        faddr_q <= free_address_i;
      end
      STEP_S1: begin
        if (is_alloc) begin
          aligned_q <= align_sum[63:0];
          gap_q     <= gap;
          skip_q    <= !act_q[idx_q] || use_q[idx_q] || align_sum[64] ||
                       (rd_len < {34'd0, gap});
          rem_q     <= rd_len - {34'd0, gap};
        end else begin
          skip_q <= !act_q[idx_q] || diff_w[64];
          rem_q  <= diff_w[63:0];
        end
      end
      STEP_S2: begin
        if (hit) begin
          cur_q  <= idx_q;
          tail_q <= tail_w[63:0];
          st_q   <= rd_st;
          len_q  <= rd_len;
          addr_q <= is_alloc ? aligned_q : rd_st;
        end
      end
      STEP_J1: begin
        p_q <= rd_prev;
        n_q <= rd_next;
      end
      STEP_J2: begin
        lenc_q <= j1 ? (len_q + rd_len) : len_q;
        nxt_q  <= j1 ? rd_next : n_q;
      end
      STEP_DONE: begin
        if (out_free) begin
          out_status_q <= cmd_i.code;
          out_addr_q   <= ((cmd_i.code == ST_OK) && (op_q != OP_INIT)) ? addr_q : '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_addr_o   = out_addr_q;

  `ARA_ASSERT(a_init_single, (cmd_i.step == STEP_INIT) |=> act_q[0] && ($countones(act_q) == 1))
  `ARA_ASSERT(a_gap_slot_free, (cmd_i.step == STEP_W1) && gap_nz |-> !act_q[fa_q])
  `ARA_ASSERT_NORST(a_err_addr_zero, out_valid_q && (out_status_q != ST_OK) |-> out_addr_q == '0)

endmodule

@@ hdl/ara_ctrl.sv @@
// ---------------------------------------------------------------------------
// Region allocator controller
// Sequences decode, table scan, free-slot search, split writes and merges.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ara_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ara_pkg::sts_t sts_i,
  output ara_pkg::cmd_t cmd_o
);
  import ara_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_DECODE = 16'h0002,
    S_SRD    = 16'h0004,
    S_S1     = 16'h0008,
    S_S2     = 16'h0010,
    S_FSCAN  = 16'h0020,
    S_LRD    = 16'h0040,
    S_W1     = 16'h0080,
    S_W2     = 16'h0100,
    S_W3     = 16'h0200,
    S_W4     = 16'h0400,
    S_J1     = 16'h0800,
    S_J2     = 16'h1000,
    S_J3     = 16'h2000,
    S_INIT   = 16'h4000,
    S_DONE   = 16'h8000
  } state_e;

  state_e  state_q, state_d;
  status_e code_q, code_d;
  step_e   step;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    step    = STEP_IDLE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          step    = STEP_LOAD;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.op)
          OP_INIT: state_d = S_INIT;
          OP_FREE: state_d = S_SRD;
          OP_ALLOC: begin
            if (sts_i.bad_alloc) begin
              code_d  = ST_BAD;
              state_d = S_DONE;
            end else begin
              state_d = S_SRD;
            end
          end
          default: begin
            code_d  = ST_BAD;
            state_d = S_DONE;
          end
        endcase
      end
      S_SRD: begin
        step    = STEP_SRD;
        state_d = S_S1;
      end
      S_S1: begin
        step    = STEP_S1;
        state_d = S_S2;
      end
      S_S2: begin
        step = STEP_S2;
        if (sts_i.hit) begin
          state_d = (sts_i.op == OP_ALLOC) ? S_FSCAN : S_LRD;
        end else if (sts_i.last) begin
          code_d  = (sts_i.op == OP_ALLOC) ? ST_NOSPACE : ST_NOTFOUND;
          state_d = S_DONE;
        end else begin
          state_d = S_S1;
        end
      end
      S_FSCAN: begin
        step = STEP_FSCAN;
        if (sts_i.fs_done) begin
          state_d = S_LRD;
        end else if (sts_i.last) begin
          code_d  = ST_FULL;
          state_d = S_DONE;
        end
      end
      S_LRD: begin
        step    = STEP_LRD;
        state_d = (sts_i.op == OP_ALLOC) ? S_W1 : S_J1;
      end
      S_W1: begin
        step    = STEP_W1;
        state_d = S_W2;
      end
      S_W2: begin
        step    = STEP_W2;
        state_d = S_W3;
      end
      S_W3: begin
        step    = STEP_W3;
        state_d = S_W4;
      end
      S_W4: begin
        step    = STEP_W4;
        code_d  = ST_OK;
        state_d = S_DONE;
      end
      S_J1: begin
        step    = STEP_J1;
        state_d = S_J2;
      end
      S_J2: begin
        step    = STEP_J2;
        state_d = S_J3;
      end
      S_J3: begin
        step    = STEP_J3;
        code_d  = ST_OK;
        state_d = S_DONE;
      end
      S_INIT: begin
        step    = STEP_INIT;
        code_d  = ST_OK;
        state_d = S_DONE;
      end
      S_DONE: begin
        step = STEP_DONE;
        // hold until the result register is free
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  assign cmd_o = '{step: step, code: code_q};

  `ARA_ASSERT(a_accept_decode, in_valid_i && in_ready_o |=> state_q == S_DECODE)
  `ARA_ASSERT(a_done_hold, (state_q == S_DONE) && !sts_i.out_free |=> state_q == S_DONE)
  `ARA_ASSERT(a_split_ok, (state_q == S_W4) |=> (state_q == S_DONE) && (code_q == ST_OK))

endmodule

@@ hdl/aligned_region_allocator_core.sv @@
// ---------------------------------------------------------------------------
// Aligned region allocator
// First-fit address-space allocator over a linked table of region records.
// ---------------------------------------------------------------------------
// Channel    Direction  Content
// s_axis     in         tuser: op; tdata: request_size, align_mode, free_address
// m_axis     out        tuser: status; tdata: region_address
// apb        in/out     space_base at 0x0, space_limit at 0x8
//
// Allocate: decode, a scan of the records, a free-slot search of up to TABLE_DEPTH slots,
// then a read and the split writes; free: decode, a scan and a read, then the merges.
// Each record memory has a single read port and a single write port.
// One item at a time; a new item is taken while the last result waits on m_axis.
// Reset clears all record flags at once, so no clearing pass is needed.
// ---------------------------------------------------------------------------
module aligned_region_allocator_core #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [135:0]                s_axis_tdata,  // request_size, align_mode, free_address
  input  logic [1:0]                  s_axis_tuser,  // op
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [63:0]                 m_axis_tdata,  // region_address
  output logic [2:0]                  m_axis_tuser,  // status
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ara_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);
  import ara_pkg::*;

  logic [63:0] space_base_q, space_limit_q;
  logic        cfg_we;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = paddr[REG_SEL] ? space_limit_q : space_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_base_q  <= '0;
      space_limit_q <= SPACE_LIMIT_RST;
    end else if (cfg_we) begin
      if (paddr[REG_SEL]) space_limit_q <= pwdata;
      else space_base_q <= pwdata;
    end
  end

  ara_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ara_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (s_axis_tuser),
    .request_size_i (s_axis_tdata[63:0]),
    .align_mode_i   (s_axis_tdata[65:64]),
    .free_address_i (s_axis_tdata[129:66]),
    .space_base_i   (space_base_q),
    .space_limit_i  (space_limit_q),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_status_o   (m_axis_tuser),
    .out_addr_o     (m_axis_tdata)
  );

endmodule

@@ bench/testbench.sv @@
// ---------------------------------------------------------------------------
// Region allocator testbench
// Drives allocate, free, init and invalid-op beats with random gaps, predicts each status
// and address from a local copy of the region table, and checks every beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import ara_pkg::*;

  localparam int DEPTH = 128;
  localparam int NO_LINK = DEPTH;
  localparam int WDOG_LIMIT = 40000;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] size;
    logic [1:0]  mode;
    logic [63:0] addr;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] addr;
  } rsp_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;

  aligned_region_allocator_core u_top (.*);

  // predictor state
  logic [63:0] base_q, limit_q;
  bit          act [DEPTH];
  bit          used [DEPTH];
  logic [63:0] rstart [DEPTH];
  logic [63:0] rlen [DEPTH];
  int          prv [DEPTH];
  int          nxt [DEPTH];

  req_t pending_q[$];
  rsp_t expected_q[$];
  logic [63:0] live_q[$];  // addresses handed out, used to pick frees
  int   mismatches = 0;
  int   unexpected = 0;
  int   idle_cycles = 0;
  bit   hold_rx = 1'b0;
  bit   driving = 1'b0;
  bit   tx_taken = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void table_clear();
    for (int i = 0; i < DEPTH; i++) begin
      act[i] = 0; used[i] = 0;
    end
  endfunction

  function automatic void join_regions(int a, int b);
    int after;
    if (a >= DEPTH || b >= DEPTH || a == b) return;
    if (!act[a] || !act[b] || used[a] || used[b]) return;
    if (nxt[a] != b || prv[b] != a) return;
    rlen[a] += rlen[b];
    after = nxt[b];
    nxt[a] = after;
    if (after < DEPTH) prv[after] = a;
    act[b] = 0; used[b] = 0;
  endfunction

  function automatic void set_rec(int i, int p, int n, logic [63:0] s, logic [63:0] l);
    act[i] = 1; used[i] = 0; rstart[i] = s; rlen[i] = l; prv[i] = p; nxt[i] = n;
  endfunction

  function automatic rsp_t allocate(logic [63:0] size, logic [1:0] mode);
    rsp_t r;
    logic [63:0] mask, aligned, gap, tail;
    int cur, fa, fb, need, have;
    r.status = ST_OK; r.addr = '0;
    cur = NO_LINK; fa = NO_LINK; fb = NO_LINK; have = 0;
    gap = 0; tail = 0; aligned = 0;
    if (size == 0 || mode > ALIGN_1G) begin
      r.status = ST_BAD; return r;
    end
    mask = (mode == ALIGN_4K) ? 64'hFFF : (mode == ALIGN_2M) ? 64'h1FFFFF : 64'h3FFFFFFF;
    for (int i = 0; i < DEPTH; i++) begin
      if (!act[i] || used[i]) continue;
      if (rstart[i] > ~mask) continue;
      aligned = (rstart[i] + mask) & ~mask;
      gap = aligned - rstart[i];
      if (gap > rlen[i]) continue;
      if (rlen[i] - gap >= size) begin
        cur = i; tail = rlen[i] - gap - size; break;
      end
    end
    if (cur == NO_LINK) begin
      r.status = ST_NOSPACE; return r;
    end
    need = (gap != 0) + (tail != 0);
    for (int i = 0; i < DEPTH && have < need; i++) begin
      if (!act[i]) begin
        if (have == 0) fa = i; else fb = i;
        have++;
      end
    end
    if (have < need) begin
      r.status = ST_FULL; return r;
    end
    if (gap != 0) begin
      int p;
      p = prv[cur];
      set_rec(fa, p, cur, rstart[cur], gap);
      if (p < DEPTH) nxt[p] = fa;
      prv[cur] = fa;
      fa = fb;
    end
    if (tail != 0) begin
      int n;
      n = nxt[cur];
      set_rec(fa, cur, n, aligned + size, tail);
      if (n < DEPTH) prv[n] = fa;
      nxt[cur] = fa;
    end
    rstart[cur] = aligned; rlen[cur] = size; used[cur] = 1;
    r.addr = aligned;
    return r;
  endfunction

  function automatic rsp_t release_region(logic [63:0] a);
    rsp_t r;
    int cur;
    r.status = ST_NOTFOUND; r.addr = '0; cur = NO_LINK;
    for (int i = 0; i < DEPTH; i++) begin
      if (act[i] && rstart[i] <= a && a - rstart[i] < rlen[i]) begin
        cur = i; break;
      end
    end
    if (cur == NO_LINK) return r;
    r.status = ST_OK; r.addr = rstart[cur];
    used[cur] = 0;
    join_regions(cur, nxt[cur]);
    join_regions(prv[cur], cur);
    return r;
  endfunction

  function automatic rsp_t predict_region_op(req_t q);
    rsp_t r;
    case (q.op)
      OP_ALLOC: r = allocate(q.size, q.mode);
      OP_FREE:  r = release_region(q.addr);
      OP_INIT: begin
        table_clear();
        set_rec(0, NO_LINK, NO_LINK, base_q, limit_q > base_q ? limit_q - base_q : 0);
        r.status = ST_OK; r.addr = '0;
      end
      default: begin
        r.status = ST_BAD; r.addr = '0;
      end
    endcase
    return r;
  endfunction

  task automatic apb_write(logic [PADDR_W-1:0] a, logic [63:0] d);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == 0) base_q = d; else limit_q = d;
  endtask

  function automatic int rand_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
           ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
  endfunction

  // driver: one beat at a time, random gaps between beats
  int tx_gap = 0;

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      req_t q;
      q = pending_q.pop_front();
      tx_taken = 1'b1;
      expected_q.push_back(predict_region_op(q));
      if (q.op == OP_ALLOC && expected_q[$].status == ST_OK)
        live_q.push_back(expected_q[$].addr);
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || !driving) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !tx_taken) begin
      // hold the beat
    end else if (tx_gap > 0) begin
      tx_gap <= tx_gap - 1;
      s_axis_tvalid <= 1'b0;
    end else if (pending_q.size() != 0) begin
      req_t q;
      q = pending_q[0];
      s_axis_tvalid <= 1'b1;
      s_axis_tuser <= q.op;
      s_axis_tdata <= {q.addr, q.mode, q.size};
      tx_gap <= rand_gap();
    end else begin
      s_axis_tvalid <= 1'b0;
    end
    tx_taken = 1'b0;
  end

  // receiver stalls
  int rx_gap = 0;
  int hold_cnt = 0;
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_rx) begin
      hold_rx = 1'b0;
      hold_cnt <= 600;
      m_axis_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      rx_gap <= ($urandom_range(0, 3) == 0) ? rand_gap() : 0;
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          unexpected++;
          if (mismatches + unexpected <= 10)
            $display("unexpected result: status %0d addr %h", m_axis_tuser, m_axis_tdata);
        end else begin
          rsp_t e;
          e = expected_q.pop_front();
          if (m_axis_tuser !== e.status || m_axis_tdata !== e.addr) begin
            mismatches++;
            if (mismatches + unexpected <= 10)
              $display("mismatch: status exp %0d got %0d, addr exp %h got %h",
                       e.status, m_axis_tuser, e.addr, m_axis_tdata);
          end
        end
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles <= 0;
      else if (expected_q.size() != 0 || pending_q.size() != 0)
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit live_addr_pick(inout logic [63:0] a);
    int i;
    if (live_q.size() == 0 || $urandom_range(0, 7) == 0) return 0;
    i = $urandom_range(0, live_q.size() - 1);
    a = live_q[i] + $urandom_range(0, 4095);
    live_q.delete(i);
    return 1;
  endfunction

  function automatic req_t rand_req();
    req_t q;
    int k;
    q.op = OP_ALLOC; q.mode = 2'($urandom_range(0, 2)); q.addr = rand64();
    k = $urandom_range(0, 99);
    if (k < 50) begin
      q.size = ($urandom_range(0, 5) == 0) ? 64'($urandom_range(1, 1 << 24))
                                            : 64'($urandom_range(1, 16)) << 12;
      if ($urandom_range(0, 9) == 0) q.size = rand64();
    end else if (k < 88) begin
      q.op = OP_FREE; q.size = rand64();
      void'(live_addr_pick(q.addr));
    end else if (k < 91) begin
      q.op = OP_INIT; q.size = rand64();
    end else if (k < 94) begin
      q.op = 2'd3; q.size = rand64(); q.mode = 2'($urandom_range(0, 3));
    end else begin
      q.size = rand64(); q.mode = 2'($urandom_range(0, 3));
      if (k == 99) q.size = 0;
    end
    return q;
  endfunction

  task automatic push_req(logic [1:0] op, logic [63:0] size, logic [1:0] mode,
                          logic [63:0] a);
    req_t q;
    q.op = op; q.size = size; q.mode = mode; q.addr = a;
    pending_q.push_back(q);
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    base_q = 0; limit_q = SPACE_LIMIT_RST;
    table_clear();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    driving = 1'b1;
    // directed: empty table, bad codes, extremes, then reset-value space
    push_req(OP_ALLOC, 64'h1000, ALIGN_4K, '0);
    push_req(OP_FREE, '0, ALIGN_4K, 64'h1234);
    push_req(2'd3, '1, 2'd3, '1);
    push_req(OP_INIT, '0, ALIGN_4K, '0);
    push_req(OP_ALLOC, '0, ALIGN_4K, '0);
    push_req(OP_ALLOC, 64'h1000, 2'd3, '0);
    push_req(OP_ALLOC, 64'h1, ALIGN_4K, '0);
    push_req(OP_ALLOC, 64'h1000, ALIGN_2M, '0);
    push_req(OP_ALLOC, 64'h1000, ALIGN_1G, '0);
    push_req(OP_ALLOC, '1, ALIGN_4K, '0);
    push_req(OP_FREE, '0, ALIGN_4K, 64'h0);
    push_req(OP_FREE, '0, ALIGN_4K, 64'h0);
    push_req(OP_FREE, '0, ALIGN_4K, 64'h4000_0000);
    push_req(OP_FREE, '0, ALIGN_4K, '1);
    drain();
    // inverted space and near-top space
    apb_write(4'h0, 64'hFFFF_FFFF_FFFF_0000);
    apb_write(4'h8, 64'h1000);
    push_req(OP_INIT, '0, ALIGN_4K, '0);
    push_req(OP_ALLOC, 64'h1, ALIGN_4K, '0);
    push_req(OP_FREE, '0, ALIGN_4K, 64'hFFFF_FFFF_FFFF_0000);
    drain();
    apb_write(4'h8, '1);
    push_req(OP_INIT, '0, ALIGN_4K, '0);
    push_req(OP_ALLOC, 64'h1, ALIGN_1G, '0);
    push_req(OP_ALLOC, 64'h100, ALIGN_4K, '0);
    push_req(OP_FREE, '0, ALIGN_4K, 64'hFFFF_FFFF_FFFF_0000);
    drain();
    // random phases over four spaces; small sizes drive table-full cases
    for (int ph = 0; ph < 4; ph++) begin
      apb_write(4'h0, (ph == 0) ? 64'h0 : (ph == 1) ? 64'h1234_5000 :
                      (ph == 2) ? 64'h3FFF_F000 : rand64() & 64'hFFFF_FFFF_F000);
      apb_write(4'h8, (ph == 3) ? '1 : 64'h40_0000_0000 + (ph << 30));
      push_req(OP_INIT, '0, ALIGN_4K, '0);
      live_q.delete();
      for (int n = 0; n < 270; n++) begin
        while (pending_q.size() > 8) @(posedge clk_i);
        pending_q.push_back(rand_req());
        if (ph == 1 && n == 100) hold_rx = 1'b1;
      end
      drain();
    end
    apb_write(4'h0, 64'h0);
    apb_write(4'h8, SPACE_LIMIT_RST);
    if (mismatches == 0 && unexpected == 0 && expected_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
